// File: hw/rtl/ibz_pkg.sv
package ibz_pkg;

	// Width of the configuration write data, set by the widest register.
	localparam int CFG_W = 13;

	// Source position and divider word width.
	localparam int DIV_W = 13;
	localparam int DIV_LANES = 4;

	// Divider lane assignment.
	localparam int LANE_COL = 0;
	localparam int LANE_ROW = 1;
	localparam int LANE_WIDTH = 2;
	localparam int LANE_HEIGHT = 3;

	// Largest source image height.
	localparam int MAX_HEIGHT = 4096;

	// Block sum width and the reciprocal used for the block average.
	localparam int SUM_W = 14;
	localparam int RECIP_W = 21;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W = SUM_W + RECIP_W;

	typedef logic [DIV_W-1:0] ibz_word_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ZOOM = 2'd0,
		REG_ENLARGE = 2'd1,
		REG_WIDTH = 2'd2,
		REG_HEIGHT = 2'd3
	} ibz_reg_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_NORM,
		ST_DIV,
		ST_RUN
	} ibz_state_t;

	// Result of the shared divider, all lanes at once.
	typedef struct packed {
		logic done;
		ibz_word_t [DIV_LANES-1:0] quo;
		logic [DIV_LANES-1:0][2:0] rem;
	} ibz_div_res_t;

	// Scaled reciprocal of z*z, rounded up, so that (sum * r) >> RECIP_SHIFT
	// gives the exact truncated quotient for every sum below 2**SUM_W.
	function automatic logic [RECIP_W-1:0] ibz_recip(input logic [3:0] z);
		logic [RECIP_W-1:0] r;
		case (z)
			4'd2: r = 21'd262144;
			4'd3: r = 21'd116509;
			4'd4: r = 21'd65536;
			4'd5: r = 21'd41944;
			4'd6: r = 21'd29128;
			4'd7: r = 21'd21400;
			4'd8: r = 21'd16384;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/ibz_ram.sv
module ibz_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read port; a read of the entry being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/ibz_div.sv
module ibz_div
	import ibz_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  ibz_word_t [DIV_LANES-1:0]        dividend,
	input  logic [3:0]                       divisor,
	output ibz_div_res_t                     res
);

	localparam int CNT_W = $clog2(DIV_W);

	ibz_word_t [DIV_LANES-1:0] dvd_q;
	logic [DIV_LANES-1:0][2:0] rem_q;
	ibz_word_t [DIV_LANES-1:0] dvd_d;
	logic [DIV_LANES-1:0][2:0] rem_d;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	// One restoring step per lane: shift in the next dividend bit and
	// subtract the divisor where it fits. The quotient bit enters the
	// dividend word from the right.
	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			logic [3:0] t;
			logic       ge;
			t = {rem_q[l], dvd_q[l][DIV_W-1]};
			ge = (t >= divisor);
			rem_d[l] = ge ? 3'(t - divisor) : 3'(t);
			dvd_d[l] = {dvd_q[l][DIV_W-2:0], ge};
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Working registers of the lanes.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign res.done = done_q;
	assign res.quo = dvd_q;
	assign res.rem = rem_q;

endmodule

// File: hw/rtl/image_box_zoom_core.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   pixel
// out      output     out_valid / out_ready out_row, out_col, grey, last
// cfg      input      cfg_wen (no wait)     cfg_index, cfg_wdata
//
// Shrink mode takes one item per cycle unless the output stalls: the column sum
// memory is read when an item is taken and written back by stage 1, with
// forwarding between back-to-back items on the same column. Enlarge mode emits
// one replica per cycle from a counter unless the output stalls. After reset
// and after every register write a pass (normalise the position, then 13 steps
// of the shared divider) runs before in_ready rises. Reset on arst_n is
// asynchronous; a low out_ready holds the whole pipeline while an output waits.
module image_box_zoom_core
	import ibz_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_ZOOM = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       pixel,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [14:0]      out_row,
	output logic [14:0]      out_col,
	output logic [7:0]       grey,
	output logic             last
);

	localparam int AW = $clog2(MAX_WIDTH);

	// Configuration registers.
	logic [3:0]       zoom_q;
	logic             enlarge_q;
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q <= 4'd1;
			enlarge_q <= 1'b0;
			width_q <= 13'd4096;
			height_q <= 13'd4096;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ZOOM: zoom_q <= cfg_wdata[3:0];
				REG_ENLARGE: enlarge_q <= cfg_wdata[0];
				REG_WIDTH: width_q <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective factor and image size after clamping.
	logic [3:0]  z_eff;
	logic [2:0]  z_m1;
	ibz_word_t   w_eff;
	ibz_word_t   h_eff;

	always_comb begin
		if (zoom_q == 4'd0) begin
			z_eff = 4'd1;
		end else if (zoom_q > 4'(MAX_ZOOM)) begin
			z_eff = 4'(MAX_ZOOM);
		end else begin
			z_eff = zoom_q;
		end
		if (width_q == '0) begin
			w_eff = 13'd1;
		end else if ({1'b0, width_q} > 14'(MAX_WIDTH)) begin
			w_eff = 13'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = 13'd1;
		end else if (height_q > 13'(MAX_HEIGHT)) begin
			h_eff = 13'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		z_m1 = 3'(z_eff - 4'd1);
	end

	// Control sequencer.
	ibz_state_t state_q;
	ibz_state_t state_d;
	logic       div_start;
	logic       run;

	ibz_div_res_t div_res;

	always_comb begin
		state_d = state_q;
		if (cfg_wen) begin
			state_d = ST_NORM;
		end else begin
			unique case (state_q)
				ST_NORM: state_d = ST_DIV;
				ST_DIV: if (div_res.done) state_d = ST_RUN;
				ST_RUN: state_d = ST_RUN;
				default: state_d = ST_NORM;
			endcase
		end
	end

	always_comb begin
		div_start = (state_q == ST_NORM);
		run = (state_q == ST_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORM;
		end else begin
			state_q <= state_d;
		end
	end

	// Stored source position, and the position moved back into the image.
	ibz_word_t   pos_col_q;
	logic [11:0] pos_row_q;
	logic        col_wrap;
	ibz_word_t   row_inc;
	ibz_word_t   nc_norm;
	logic [11:0] nr_norm;

	always_comb begin
		col_wrap = (pos_col_q >= w_eff);
		row_inc = col_wrap ? 13'(pos_row_q) + 13'd1 : 13'(pos_row_q);
		nr_norm = (row_inc >= h_eff) ? '0 : row_inc[11:0];
		nc_norm = col_wrap ? '0 : pos_col_q;
	end

	ibz_word_t [DIV_LANES-1:0] div_dvd;

	always_comb begin
		div_dvd[LANE_COL] = nc_norm;
		div_dvd[LANE_ROW] = 13'(nr_norm);
		div_dvd[LANE_WIDTH] = w_eff;
		div_dvd[LANE_HEIGHT] = h_eff;
	end

	ibz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (z_eff),
		.res      (div_res)
	);

	// Working position with its block counters: column in block, output
	// column, row in block, output row, and the kept block counts.
	ibz_word_t   nc_q;
	logic [11:0] nr_q;
	logic [2:0]  c_q;
	ibz_word_t   oc_q;
	logic [2:0]  r_q;
	logic [11:0] orow_q;
	ibz_word_t   qw_q;
	ibz_word_t   qh_q;

	logic        accept;
	logic        advance;
	ibz_word_t   col_nx;
	ibz_word_t   row_nx;
	logic        col_end;
	logic        row_end;
	logic        c_last;
	logic        r_last;
	logic        kept;
	logic        shrink_acc;

	assign accept = in_valid & in_ready;

	always_comb begin
		col_nx = nc_q + 13'd1;
		row_nx = 13'(nr_q) + 13'd1;
		col_end = (col_nx >= w_eff);
		row_end = (row_nx >= h_eff);
		c_last = (c_q == z_m1);
		r_last = (r_q == z_m1);
		kept = (oc_q < qw_q) && (13'(orow_q) < qh_q);
		shrink_acc = accept && !enlarge_q && kept;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_NORM) begin
			nc_q <= nc_norm;
			nr_q <= nr_norm;
		end else if (state_q == ST_DIV && div_res.done) begin
			c_q <= div_res.rem[LANE_COL];
			oc_q <= div_res.quo[LANE_COL];
			r_q <= div_res.rem[LANE_ROW];
			orow_q <= div_res.quo[LANE_ROW][11:0];
			qw_q <= div_res.quo[LANE_WIDTH];
			qh_q <= div_res.quo[LANE_HEIGHT];
		end else if (accept) begin
			if (col_end) begin
				nc_q <= '0;
				c_q <= '0;
				oc_q <= '0;
				if (row_end) begin
					nr_q <= '0;
					r_q <= '0;
					orow_q <= '0;
				end else begin
					nr_q <= row_nx[11:0];
					r_q <= r_last ? 3'd0 : r_q + 3'd1;
					orow_q <= r_last ? orow_q + 12'd1 : orow_q;
				end
			end else begin
				nc_q <= col_nx;
				c_q <= c_last ? 3'd0 : c_q + 3'd1;
				oc_q <= c_last ? oc_q + 13'd1 : oc_q;
			end
		end
	end

	// Stored position follows every item; register writes leave it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_col_q <= '0;
			pos_row_q <= '0;
		end else if (accept) begin
			pos_col_q <= col_end ? '0 : col_nx;
			if (col_end) begin
				pos_row_q <= row_end ? '0 : row_nx[11:0];
			end else begin
				pos_row_q <= nr_q;
			end
		end
	end

	// Output register state; the whole datapath moves when it can take more.
	logic out_valid_q;

	assign advance = !out_valid_q || out_ready;

	// Shrink stage 1: read data back, add, write the column sum.
	logic              s1_valid_q;
	logic [7:0]        pix_s1;
	logic [AW-1:0]     oc_s1;
	logic              first_s1;
	logic              fin_s1;
	logic [11:0]       orow_s1;
	logic              hz_s1;
	logic [SUM_W-1:0]  fwd_q;
	logic [SUM_W-1:0]  ram_rdata;
	logic [SUM_W-1:0]  old_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic              ram_we;

	always_ff @(posedge clk) begin
		if (shrink_acc) begin
			pix_s1 <= pixel;
			oc_s1 <= oc_q[AW-1:0];
			first_s1 <= (r_q == 3'd0) && (c_q == 3'd0);
			fin_s1 <= r_last && c_last;
			orow_s1 <= orow_q;
			hz_s1 <= s1_valid_q && (oc_s1 == oc_q[AW-1:0]);
		end
	end

	always_comb begin
		old_s1 = hz_s1 ? fwd_q : ram_rdata;
		sum_s1 = first_s1 ? SUM_W'(pix_s1) : old_s1 + SUM_W'(pix_s1);
		ram_we = s1_valid_q && advance;
	end

	// Value written by the previous item, for a read that overlapped it.
	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_q <= sum_s1;
		end
	end

	ibz_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (oc_s1),
		.wdata (sum_s1),
		.re    (shrink_acc),
		.raddr (oc_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Shrink stage 2: block average by reciprocal multiplication.
	logic               s2_valid_q;
	logic [SUM_W-1:0]   sum_s2;
	logic [11:0]        orow_s2;
	logic [AW-1:0]      oc_s2;
	logic [RECIP_W-1:0] recip_s2;
	logic [PROD_W-1:0]  prod_s2;

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q && fin_s1) begin
			sum_s2 <= sum_s1;
			orow_s2 <= orow_s1;
			oc_s2 <= oc_s1;
		end
	end

	always_comb begin
		recip_s2 = ibz_recip(z_eff);
		prod_s2 = PROD_W'(sum_s2) * PROD_W'(recip_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= shrink_acc;
			s2_valid_q <= s1_valid_q && fin_s1;
		end
	end

	// Enlarge: replica counters over one z by z block.
	logic        busy_q;
	logic [2:0]  rep_i_q;
	logic [2:0]  rep_j_q;
	logic [15:0] base_row_q;
	logic [16:0] base_col_q;
	logic [7:0]  pix_e_q;
	logic        rep_last;

	assign rep_last = (rep_i_q == z_m1) && (rep_j_q == z_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rep_i_q <= '0;
			rep_j_q <= '0;
		end else if (accept && enlarge_q) begin
			busy_q <= 1'b1;
			rep_i_q <= '0;
			rep_j_q <= '0;
		end else if (busy_q && advance) begin
			if (rep_last) begin
				busy_q <= 1'b0;
			end else if (rep_j_q == z_m1) begin
				rep_j_q <= '0;
				rep_i_q <= rep_i_q + 3'd1;
			end else begin
				rep_j_q <= rep_j_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && enlarge_q) begin
			base_row_q <= 16'(nr_q) * 16'(z_eff);
			base_col_q <= 17'(nc_q) * 17'(z_eff);
			pix_e_q <= pixel;
		end
	end

	// A new item may enter as the last replica of the previous one leaves.
	assign in_ready = run && advance && (!busy_q || rep_last);

	// Output register.
	logic [14:0] out_row_q;
	logic [14:0] out_col_q;
	logic [7:0]  grey_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s2_valid_q || busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (s2_valid_q) begin
				out_row_q <= 15'(orow_s2);
				out_col_q <= 15'(oc_s2);
				grey_q <= prod_s2[RECIP_SHIFT+7:RECIP_SHIFT];
				last_q <= 1'b1;
			end else if (busy_q) begin
				out_row_q <= 15'(base_row_q + 16'(rep_i_q));
				out_col_q <= 15'(base_col_q + 17'(rep_j_q));
				grey_q <= pix_e_q;
				last_q <= rep_last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign grey = grey_q;
	assign last = last_q;

	// Items are only taken once the block counters are in step.
	a_ready_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_RUN))
		else $error("in_ready raised outside the run state");

	// Block counters stay inside one block while items are taken.
	a_counters_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (c_q <= z_m1 && r_q <= z_m1))
		else $error("block counter beyond the zoom factor");

	// Shrink pipeline and replica emission never share the output register.
	a_modes_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q || s2_valid_q) |-> !busy_q)
		else $error("shrink item in flight during replica emission");

	// The last replica ends the block unless a new item enters at once.
	a_replica_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && advance && rep_last && !accept) |=> !busy_q)
		else $error("replica emission ran past the last copy");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ibz_pkg::*;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_ZOOM = 8;
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam int LONG_HOLD = 300;
	localparam int RAND_ITEMS = 130;

	// One scaled pixel as it leaves the block.
	typedef struct packed {
		logic [14:0] row;
		logic [14:0] col;
		logic [7:0]  grey;
		logic        last;
	} zoom_px_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [1:0]       cfg_index = REG_ZOOM;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       pixel = 8'd0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [14:0]      out_row;
	logic [14:0]      out_col;
	logic [7:0]       grey;
	logic             last;

	// Source pixels waiting to be offered, and scaled pixels still to arrive.
	logic [7:0] src_px_q [$];
	zoom_px_t   zoomed_px_q [$];

	int fault_count = 0;
	bit no_idle = 1'b0;
	int hold_serial = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Register copies and stream position as the block should hold them.
	logic [3:0]       cfg_zoom = 4'd1;
	logic             cfg_enlarge = 1'b0;
	logic [12:0]      cfg_width = 13'd4096;
	logic [12:0]      cfg_height = 13'd4096;
	int               pos_row = 0;
	int               pos_col = 0;
	logic [SUM_W-1:0] col_sum [MAX_WIDTH];
	bit               sum_valid [MAX_WIDTH];

	image_box_zoom_core #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_ZOOM(MAX_ZOOM)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row(out_row),
		.out_col(out_col),
		.grey(grey),
		.last(last)
	);

	always #5 clk = ~clk;

	// A zero register acts as one; anything above the limit acts as the limit.
	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Work out the scaled pixels caused by one source pixel and queue them.
	task automatic scale_pixel(input logic [7:0] pix);
		int unsigned z, w, h, kept_w, kept_h, oc;
		int unsigned i, j;
		zoom_px_t res;
		z = clamp_reg(cfg_zoom, MAX_ZOOM);
		w = clamp_reg(cfg_width, MAX_WIDTH);
		h = clamp_reg(cfg_height, MAX_HEIGHT);
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
		end
		if (pos_row >= h)
			pos_row = 0;
		if (cfg_enlarge) begin
			// Replicate into a z by z block, row by row.
			for (i = 0; i < z; i++) begin
				for (j = 0; j < z; j++) begin
					res.row = 15'(pos_row * z + i);
					res.col = 15'(pos_col * z + j);
					res.grey = pix;
					res.last = (i == z - 1) && (j == z - 1);
					zoomed_px_q.push_back(res);
				end
			end
		end else begin
			// Accumulate per output column; the last pixel of a block gives the mean.
			kept_w = (w / z) * z;
			kept_h = (h / z) * z;
			if (pos_col < kept_w && pos_row < kept_h) begin
				oc = pos_col / z;
				if (pos_row % z == 0 && pos_col % z == 0)
					col_sum[oc] = SUM_W'(pix);
				else
					col_sum[oc] = col_sum[oc] + SUM_W'(pix);
				sum_valid[oc] = 1'b1;
				if (pos_row % z == z - 1 && pos_col % z == z - 1) begin
					res.row = 15'(pos_row / z);
					res.col = 15'(oc);
					res.grey = 8'(col_sum[oc] / (z * z));
					res.last = 1'b1;
					zoomed_px_q.push_back(res);
				end
			end
		end
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h)
				pos_row = 0;
		end
	endtask

	// Carrying on from the present position under new settings must never
	// make the block add to a column sum that was never written.
	function automatic bit resume_is_safe(input int unsigned zr, input int unsigned enl,
			input int unsigned wr, input int unsigned hr);
		int unsigned z, w, h, r, c, kept_w, kept_h, i;
		if (enl != 0)
			return 1'b1;
		z = clamp_reg(zr, MAX_ZOOM);
		w = clamp_reg(wr, MAX_WIDTH);
		h = clamp_reg(hr, MAX_HEIGHT);
		r = pos_row;
		c = pos_col;
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = 0;
		kept_w = (w / z) * z;
		kept_h = (h / z) * z;
		if (kept_w == 0 || kept_h == 0 || r >= kept_h || (r % z == 0 && c == 0))
			return 1'b1;
		for (i = 0; i < kept_w / z; i++)
			if (!sum_valid[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Write one register while the block is idle, and keep the copy in step.
	task automatic set_reg(input ibz_reg_t idx, input int unsigned val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_ZOOM: cfg_zoom = 4'(val);
			REG_ENLARGE: cfg_enlarge = 1'(val);
			REG_WIDTH: cfg_width = 13'(val);
			REG_HEIGHT: cfg_height = 13'(val);
		endcase
	endtask

	// Wait until every item is taken and every scaled pixel has come back,
	// then give the pipeline time to finish items that cause no result.
	task automatic wait_idle();
		int settled;
		while (src_px_q.size() != 0 || in_valid || zoomed_px_q.size() != 0)
			@(negedge clk);
		settled = 0;
		while (settled < 12) begin
			@(negedge clk);
			if (out_ready)
				settled++;
		end
	endtask

	// Source side: offer queued pixels, holding each until it is taken.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			scale_pixel(pixel);
		if (in_valid && !in_ready) begin
			// Item still on offer; keep it unchanged.
		end else if (src_px_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 20)) begin
			in_valid <= 1'b1;
			pixel <= src_px_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result side pacing, with an occasional long hold-off.
	always @(posedge clk) begin
		if (hold_seen != hold_serial) begin
			hold_seen = hold_serial;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= 20);
		end
	end

	// Compare each scaled pixel with the oldest one expected.
	always @(posedge clk) begin
		zoom_px_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_row, out_col, grey, last};
			if (zoomed_px_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected pixel: row %0d col %0d grey %0d last %0b",
						got.row, got.col, got.grey, got.last);
			end else begin
				want = zoomed_px_q.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
							want.row, want.col, want.grey, want.last,
							got.row, got.col, got.grey, got.last);
				end
			end
		end
	end

	// Stimulus: directed cases, then random phases of settings and pixels.
	initial begin
		int unsigned zr, enl, wr, hr, z, w, h, n, fill_kind;
		int phase_no, rand_items;
		phase_no = 0;
		rand_items = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: shrink by one along a full-width row.
		src_px_q.push_back(8'h00);
		src_px_q.push_back(8'hFF);
		src_px_q.push_back(8'hAA);
		src_px_q.push_back(8'h55);
		wait_idle();

		// Enlarge with a zoom above the maximum; the narrower row moves the
		// position past its end, so it steps on to the next row.
		set_reg(REG_ZOOM, 15);
		set_reg(REG_ENLARGE, 1);
		set_reg(REG_WIDTH, 3);
		src_px_q.push_back(8'hFF);
		src_px_q.push_back(8'h00);
		wait_idle();

		// Zero zoom and zero sizes all act as one.
		set_reg(REG_ZOOM, 0);
		set_reg(REG_HEIGHT, 0);
		set_reg(REG_WIDTH, 0);
		src_px_q.push_back(8'($urandom));
		wait_idle();

		// Shrink by two on a 3 by 3 image: one block, the last row and column dropped.
		set_reg(REG_ZOOM, 2);
		set_reg(REG_ENLARGE, 0);
		set_reg(REG_HEIGHT, 3);
		set_reg(REG_WIDTH, 3);
		repeat (9) src_px_q.push_back(8'($urandom));
		wait_idle();

		// Oversized width and height clamp to the largest image.
		set_reg(REG_ENLARGE, 1);
		set_reg(REG_HEIGHT, CFG_MAX);
		set_reg(REG_WIDTH, CFG_MAX);
		repeat (2) src_px_q.push_back(8'($urandom));
		wait_idle();

		while (rand_items < RAND_ITEMS) begin
			enl = $urandom_range(0, 1);
			case ($urandom_range(0, 9))
				0: zr = 0;
				1: zr = $urandom_range(MAX_ZOOM + 1, 15);
				default: zr = $urandom_range(1, MAX_ZOOM);
			endcase
			case ($urandom_range(0, 9))
				0: wr = 0;
				1: wr = $urandom_range(MAX_WIDTH, CFG_MAX);
				default: wr = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 9))
				0: hr = 0;
				1: hr = $urandom_range(MAX_HEIGHT, CFG_MAX);
				default: hr = $urandom_range(1, 12);
			endcase
			fill_kind = $urandom_range(0, 9);
			if (phase_no == 0) begin
				// Small enlarge run that will be held up at the output.
				enl = 1;
				zr = 2;
				wr = 4;
				hr = 3;
			end else if (phase_no == 1) begin
				// Full-sized blocks of white with no idling: the largest block sum.
				enl = 0;
				zr = MAX_ZOOM;
				wr = 8;
				hr = 8;
				fill_kind = 0;
			end
			z = clamp_reg(zr, MAX_ZOOM);
			w = clamp_reg(wr, MAX_WIDTH);
			h = clamp_reg(hr, MAX_HEIGHT);
			if (enl != 0)
				n = $urandom_range(1, (z * z > 10) ? 256 / (z * z) : 24);
			else if (w * h <= 64)
				n = w * h * $urandom_range(1, 2);
			else
				n = $urandom_range(8, 32);
			if (phase_no == 0)
				n = 12;
			else if (phase_no == 1)
				n = 64;
			if (rand_items + n > RAND_ITEMS)
				n = RAND_ITEMS - rand_items;

			// Mostly start a fresh frame: a one-pixel image wraps the position
			// back to the origin. Otherwise carry on mid-frame where that is safe.
			if ($urandom_range(0, 2) != 0 || !resume_is_safe(zr, enl, wr, hr)) begin
				set_reg(REG_HEIGHT, 1);
				set_reg(REG_WIDTH, 1);
				src_px_q.push_back(8'($urandom));
				wait_idle();
			end
			set_reg(REG_ZOOM, zr);
			set_reg(REG_ENLARGE, enl);
			set_reg(REG_HEIGHT, hr);
			set_reg(REG_WIDTH, wr);

			no_idle = (phase_no == 1);
			repeat (n) begin
				case (fill_kind)
					0: src_px_q.push_back(8'hFF);
					1: src_px_q.push_back(8'h00);
					default: src_px_q.push_back(8'($urandom));
				endcase
			end
			if (phase_no == 0)
				hold_serial++;
			rand_items += n;
			phase_no++;
			wait_idle();
			no_idle = 1'b0;
		end

		wait_idle();
		if (fault_count == 0 && zoomed_px_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Guard against a hung block.
	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/ibz_pkg.sv
hw/rtl/ibz_ram.sv
hw/rtl/ibz_div.sv
hw/rtl/image_box_zoom_core.sv
tb/sv/tb_top.sv
